@@ hw/rtl/sfr_pkg.sv @@
package sfr_pkg;

    localparam int FRAME_LEN   = 16;
    localparam int FILL_W      = $clog2(FRAME_LEN);
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] HDR_BYTE    = 8'hAA;
    localparam logic [7:0] ID_BYTE     = 8'h03;
    localparam logic [7:0] LEN_BYTE    = 8'h0B;
    localparam logic [7:0] TAIL_BYTE   = 8'hBB;
    localparam logic [7:0] DIR_REVERSE = 8'h01;

    // byte positions within a complete frame, oldest byte first
    localparam int POS_HDR     = 0;
    localparam int POS_ID      = 1;
    localparam int POS_LEN     = 2;
    localparam int POS_STATUS  = 3;
    localparam int POS_DIR     = 5;
    localparam int POS_L_LO    = 6;
    localparam int POS_L_HI    = 7;
    localparam int POS_R_LO    = 9;
    localparam int POS_R_HI    = 10;
    localparam int POS_BATT    = 11;
    localparam int POS_SERVO   = 12;
    localparam int POS_SUM_LO  = 3;
    localparam int POS_SUM_HI  = 13;
    localparam int POS_CHK     = 14;

    typedef struct packed {
        logic [7:0] status;
        logic [7:0] dir;
        logic [7:0] l_lo;
        logic [7:0] l_hi;
        logic [7:0] r_lo;
        logic [7:0] r_hi;
        logic [7:0] batt;
        logic [7:0] servo;
    } t_frame;

endpackage

@@ hw/rtl/sfr_front.sv @@
module sfr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [7:0]    i_rx_byte,
    input  logic          i_q_full,
    output logic          o_q_push,
    output sfr_pkg::t_frame o_q_frame
);
    import sfr_pkg::*;

    logic [7:0]        r_win [FRAME_LEN];
    logic [7:0]        r_sum;
    logic [7:0]        n_sum;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic              accept;
    logic              full_window;
    logic              frame_ok;

    assign accept      = i_push && !i_q_full;
    assign full_window = (r_fill == FILL_W'(FRAME_LEN - 1));

    // running sum of the checksum span, tracked across the shift
    assign n_sum = r_sum - r_win[POS_SUM_LO] + r_win[POS_SUM_HI + 1];

    // checks look at the window as it will be after this byte shifts in
    assign frame_ok = (r_win[POS_HDR + 1] == HDR_BYTE)
                   && (r_win[POS_ID + 1] == ID_BYTE)
                   && (r_win[POS_LEN + 1] == LEN_BYTE)
                   && (r_win[POS_CHK + 1] == n_sum)
                   && (i_rx_byte == TAIL_BYTE);

    always_comb begin
        if (!full_window) begin
            n_fill = r_fill + FILL_W'(1);
        end else if (frame_ok) begin
            n_fill = '0;
        end else begin
            n_fill = r_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_sum  <= '0;
            for (int i = 0; i < FRAME_LEN; i++) begin
                r_win[i] <= '0;
            end
        end else if (accept) begin
            r_fill <= n_fill;
            r_sum  <= n_sum;
            for (int i = 0; i < FRAME_LEN - 1; i++) begin
                r_win[i] <= r_win[i + 1];
            end
            r_win[FRAME_LEN - 1] <= i_rx_byte;
        end
    end

    assign o_q_push = accept && full_window && frame_ok;

    assign o_q_frame.status = r_win[POS_STATUS + 1];
    assign o_q_frame.dir    = r_win[POS_DIR + 1];
    assign o_q_frame.l_lo   = r_win[POS_L_LO + 1];
    assign o_q_frame.l_hi   = r_win[POS_L_HI + 1];
    assign o_q_frame.r_lo   = r_win[POS_R_LO + 1];
    assign o_q_frame.r_hi   = r_win[POS_R_HI + 1];
    assign o_q_frame.batt   = r_win[POS_BATT + 1];
    assign o_q_frame.servo  = r_win[POS_SERVO + 1];

endmodule

@@ hw/rtl/sfr_queue.sv @@
module sfr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sfr_pkg::t_frame i_frame,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output sfr_pkg::t_frame o_frame
);
    import sfr_pkg::*;

    t_frame              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_frame = r_mem[r_rd_ptr];

    function automatic logic [QUEUE_AW-1:0] ptr_inc(input logic [QUEUE_AW-1:0] p);
        logic [QUEUE_AW-1:0] q;
        if (p == QUEUE_AW'(QUEUE_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + QUEUE_AW'(1);
        end
        return q;
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QUEUE_CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QUEUE_CW'(1);
            end
        end
    end

endmodule

@@ hw/rtl/sfr_back.sv @@
module sfr_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    input  sfr_pkg::t_frame i_q_frame,
    output logic            o_q_pop,
    output logic            o_empty,
    input  logic            i_pop,
    output logic [7:0]      o_drive_status,
    output logic [15:0]     o_left_speed,
    output logic [15:0]     o_right_speed,
    output logic            o_reverse,
    output logic signed [7:0] o_steer_angle,
    output logic [7:0]      o_battery_level
);
    import sfr_pkg::*;

    logic              r_valid;
    logic              load;
    logic [15:0]       n_left;
    logic [15:0]       n_right;
    logic [7:0]        r_status;
    logic [15:0]       r_left;
    logic [15:0]       r_right;
    logic              r_reverse;
    logic signed [7:0] r_angle;
    logic [7:0]        r_batt;

    assign load    = !r_valid || i_pop;
    assign o_q_pop = load && !i_q_empty;
    assign n_left  = {i_q_frame.l_hi, i_q_frame.l_lo};
    assign n_right = {i_q_frame.r_hi, i_q_frame.r_lo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= !i_q_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_status  <= i_q_frame.status;
            r_left    <= n_left;
            r_right   <= n_right;
            r_reverse <= (i_q_frame.dir == DIR_REVERSE);
            // servo reads zero while the drive is stopped
            if (n_left == '0 && n_right == '0) begin
                r_angle <= '0;
            end else begin
                r_angle <= $signed(i_q_frame.servo);
            end
            r_batt    <= i_q_frame.batt;
        end
    end

    assign o_empty         = !r_valid;
    assign o_drive_status  = r_status;
    assign o_left_speed    = r_left;
    assign o_right_speed   = r_right;
    assign o_reverse       = r_reverse;
    assign o_steer_angle   = r_angle;
    assign o_battery_level = r_batt;

endmodule

@@ hw/rtl/status_frame_receiver.sv @@
// a frame's result shows on the result ports after it passes the frame queue entry and then
//   the output register, when the output is free
// throughput: one byte per cycle while full is low; full rises only when two decoded frames wait behind
//   an output that is not popped (two-entry frame queue plus output register)
// reset: synchronous, active low; clears the byte window, fill count, checksum and queue,
//   result side reads empty; no clearing pass, bytes accepted in the cycle after reset
module status_frame_receiver (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [7:0]        i_rx_byte,
    output logic              o_empty,
    input  logic              i_pop,
    output logic [7:0]        o_drive_status,
    output logic [15:0]       o_left_speed,
    output logic [15:0]       o_right_speed,
    output logic              o_reverse,
    output logic signed [7:0] o_steer_angle,
    output logic [7:0]        o_battery_level
);
    import sfr_pkg::*;

    logic   q_push;
    logic   q_full;
    t_frame wr_frame;
    t_frame rd_frame;
    logic   q_empty;
    logic   q_pop;

    assign o_full = q_full;

    sfr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (i_push),
        .i_rx_byte (i_rx_byte),
        .i_q_full  (q_full),
        .o_q_push  (q_push),
        .o_q_frame (wr_frame)
    );

    sfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_frame (wr_frame),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_frame (rd_frame)
    );

    sfr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_q_frame       (rd_frame),
        .o_q_pop         (q_pop),
        .o_empty         (o_empty),
        .i_pop           (i_pop),
        .o_drive_status  (o_drive_status),
        .o_left_speed    (o_left_speed),
        .o_right_speed   (o_right_speed),
        .o_reverse       (o_reverse),
        .o_steer_angle   (o_steer_angle),
        .o_battery_level (o_battery_level)
    );

endmodule

@@ hw/rtl/sfr_checker.sv @@
module sfr_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_push,
    input logic              o_full,
    input logic              o_empty,
    input logic              i_pop,
    input logic [15:0]       o_left_speed,
    input logic [15:0]       o_right_speed,
    input logic signed [7:0] o_steer_angle
);

    // nothing waits on the result side right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty)
        else $error("result side not empty after reset");

    a_reset_not_full: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_full)
        else $error("input side full after reset");

    // stopped drive always reports a centered servo
    a_angle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_left_speed == 16'd0 && o_right_speed == 16'd0)
            |-> (o_steer_angle == 8'sd0))
        else $error("steer angle not zero with both speeds zero");

    // a result into an empty output comes from a byte transfer that went through the queue and output register
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_empty) |-> $past(i_push && !o_full, 2))
        else $error("result appeared without a matching byte transfer");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_left_speed)))
        else $error("waiting result changed before transfer");

endmodule

bind status_frame_receiver sfr_checker u_sfr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_push        (i_push),
    .o_full        (o_full),
    .o_empty       (o_empty),
    .i_pop         (i_pop),
    .o_left_speed  (o_left_speed),
    .o_right_speed (o_right_speed),
    .o_steer_angle (o_steer_angle)
);
